FILE: design/obp_pkg.sv
// Shared types for the price level order book.
// No dependencies.
package obp_pkg;

  typedef struct packed {
    logic        valid;
    logic [31:0] price;
    logic [31:0] qty;
  } lvl_t;

  typedef struct packed {
    logic        clr;
    logic        era;
    logic        add;
    logic        rep;
    logic        ins_en;
    logic [31:0] key;
    logic [31:0] qty;
  } cell_op_t;

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_REPLACE = 3'd2;
  localparam logic [2:0] MODE_CLEAR = 3'd3;
  localparam logic [2:0] MODE_QUERY = 3'd4;

  localparam logic [35:0] MAX36 = 36'hFFFFFFFFF;

endpackage

FILE: design/obp_cell.sv
// One price level cell of a sorted side table.
// Depends on obp_pkg.
module obp_cell #(
  parameter bit ASK = 1'b0
) (
  input  logic              clk,
  input  logic              rst,
  input  obp_pkg::cell_op_t op,
  input  obp_pkg::lvl_t     prv,
  input  obp_pkg::lvl_t     nxt,
  input  logic              pre_in,
  input  logic              c_prev,
  output obp_pkg::lvl_t     d,
  output logic              match,
  output logic              pre_out,
  output logic              c_out
);
  obp_pkg::lvl_t d_next;
  logic          kill;
  logic [32:0]   sum;

  assign match   = d.valid && (d.price == op.key);
  assign kill    = match && (op.rep || (op.qty >= d.qty));
  assign pre_out = pre_in | (op.era & kill);
  assign c_out   = !d.valid || (ASK ? (op.key < d.price) : (op.key > d.price));
  assign sum     = {1'b0, d.qty} + {1'b0, op.qty};

  always_comb begin
    d_next = d;
    if (op.clr) begin
      d_next = '0;
    end else if (op.era) begin
      if (pre_out) begin
        d_next = nxt;
      end else if (match) begin
        d_next.qty = d.qty - op.qty;
      end
    end else if (op.add) begin
      if (match) begin
        d_next.qty = sum[32] ? 32'hFFFFFFFF : sum[31:0];
      end else if (op.ins_en && c_out) begin
        if (c_prev) begin
          d_next = prv;
        end else begin
          d_next.valid = 1'b1;
          d_next.price = op.key;
          d_next.qty   = op.qty;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d <= '0;
    end else begin
      d <= d_next;
    end
  end
endmodule

FILE: design/obp_chain.sv
// Row of level cells forming one sorted side, best level at cell 0.
// Depends on obp_pkg and obp_cell.
module obp_chain #(
  parameter int  LEVELS = 16,
  parameter bit  ASK    = 1'b0
) (
  input  logic              clk,
  input  logic              rst,
  input  obp_pkg::cell_op_t op,
  output obp_pkg::lvl_t     cells [LEVELS],
  output logic              any_match,
  output logic [31:0]       hit_qty
);
  logic [LEVELS:0]   pre;
  logic [LEVELS-1:0] c;
  logic [LEVELS-1:0] m;
  obp_pkg::lvl_t     prv [LEVELS];
  obp_pkg::lvl_t     nxt [LEVELS];
  logic [LEVELS-1:0] cp;

  assign pre[0] = 1'b0;

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prv[i] = '0;
      assign cp[i]  = 1'b0;
    end else begin : g_mid
      assign prv[i] = cells[i-1];
      assign cp[i]  = c[i-1];
    end
    if (i == LEVELS - 1) begin : g_last
      assign nxt[i] = '0;
    end else begin : g_nl
      assign nxt[i] = cells[i+1];
    end
    obp_cell #(.ASK(ASK)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .op     (op),
      .prv    (prv[i]),
      .nxt    (nxt[i]),
      .pre_in (pre[i]),
      .c_prev (cp[i]),
      .d      (cells[i]),
      .match  (m[i]),
      .pre_out(pre[i+1]),
      .c_out  (c[i])
    );
  end

  assign any_match = |m;

  always_comb begin
    hit_qty = '0;
    for (int i = 0; i < LEVELS; i++) begin
      hit_qty = hit_qty | (m[i] ? cells[i].qty : 32'd0);
    end
  end
endmodule

FILE: design/price_level_order_book.sv
// Price level order book: two cell chains (bids best-high, asks best-low).
// Depends on obp_pkg and obp_chain.
// Sequencing: erase pass, add pass and report pass as the mode needs; strobe is
// registered from the report pass; busy until the report pass ends, so no new
// item is taken mid-flight. Results cannot be held off by the receiver.
// Reset clears both tables, totals and the update counter.
module price_level_order_book #(
  parameter int LEVELS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         mode,
  input  logic               side,
  input  logic [31:0]        price,
  input  logic [31:0]        rep_price,
  input  logic [31:0]        quantity,
  input  logic [3:0]         level_index,
  output logic               strobe,
  output logic [31:0]        best_bid,
  output logic [31:0]        best_ask,
  output logic signed [32:0] spread,
  output logic [32:0]        mid_half_ticks,
  output logic [35:0]        bid_volume,
  output logic [35:0]        ask_volume,
  output logic [31:0]        liquidity_at_price,
  output logic [31:0]        level_price,
  output logic [31:0]        level_quantity,
  output logic               level_valid,
  output logic [31:0]        update_count,
  output logic               side_full
);
  localparam int TW0 = 32 + $clog2(LEVELS + 1);
  localparam int TW  = (TW0 > 36) ? TW0 : 36;
  localparam int IW  = $clog2(LEVELS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ERASE = 2'd1;
  localparam logic [1:0] ST_ADD   = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]  state, state_next;
  logic [2:0]  r_mode;
  logic        r_side;
  logic [31:0] r_price, r_rep_price, r_qty;
  logic [3:0]  r_index;
  logic [TW-1:0] bid_total, ask_total;
  logic        full;

  obp_pkg::cell_op_t op, op_bid, op_ask;
  obp_pkg::lvl_t     bid_cells [LEVELS];
  obp_pkg::lvl_t     ask_cells [LEVELS];
  logic              bid_any, ask_any, s_any;
  logic [31:0]       bid_hit, ask_hit, s_hit;
  logic              s_last_valid;
  logic [TW-1:0]     s_total, s_total_next;
  logic [32:0]       sum;
  logic [31:0]       sat;
  obp_pkg::lvl_t     rank_lvl;
  logic              rank_ok;
  logic [31:0]       bb, ba;

  assign busy = (state != ST_IDLE);

  assign s_any        = r_side ? ask_any : bid_any;
  assign s_hit        = r_side ? ask_hit : bid_hit;
  assign s_last_valid = r_side ? ask_cells[LEVELS-1].valid : bid_cells[LEVELS-1].valid;
  assign s_total      = r_side ? ask_total : bid_total;
  assign sum          = {1'b0, s_hit} + {1'b0, r_qty};
  assign sat          = sum[32] ? 32'hFFFFFFFF : sum[31:0];

  always_comb begin
    op        = '0;
    op.qty    = r_qty;
    op.key    = r_price;
    op.rep    = (r_mode == obp_pkg::MODE_REPLACE);
    op.ins_en = !s_any && !s_last_valid;
    if (state == ST_ERASE) begin
      op.clr = (r_mode == obp_pkg::MODE_CLEAR);
      op.era = (r_mode != obp_pkg::MODE_CLEAR);
    end else if (state == ST_ADD) begin
      op.add = 1'b1;
      if (r_mode == obp_pkg::MODE_REPLACE) begin
        op.key = r_rep_price;
      end
    end
    op_bid     = op;
    op_ask     = op;
    op_bid.era = op.era & !r_side;
    op_bid.add = op.add & !r_side;
    op_ask.era = op.era & r_side;
    op_ask.add = op.add & r_side;
  end

  obp_chain #(.LEVELS(LEVELS), .ASK(1'b0)) u_bid (
    .clk(clk), .rst(rst), .op(op_bid),
    .cells(bid_cells), .any_match(bid_any), .hit_qty(bid_hit)
  );

  obp_chain #(.LEVELS(LEVELS), .ASK(1'b1)) u_ask (
    .clk(clk), .rst(rst), .op(op_ask),
    .cells(ask_cells), .any_match(ask_any), .hit_qty(ask_hit)
  );

  always_comb begin
    s_total_next = s_total;
    if (state == ST_ERASE && s_any) begin
      if (op.rep || r_qty >= s_hit) begin
        s_total_next = s_total - TW'(s_hit);
      end else begin
        s_total_next = s_total - TW'(r_qty);
      end
    end else if (state == ST_ADD) begin
      if (s_any) begin
        s_total_next = s_total + TW'(sat) - TW'(s_hit);
      end else if (op.ins_en) begin
        s_total_next = s_total + TW'(r_qty);
      end
    end
  end

  always_comb begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (mode == obp_pkg::MODE_ADD) begin
            state_next = ST_ADD;
          end else if (mode == obp_pkg::MODE_REMOVE || mode == obp_pkg::MODE_REPLACE ||
                       mode == obp_pkg::MODE_CLEAR) begin
            state_next = ST_ERASE;
          end else begin
            state_next = ST_OUT;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ERASE: state_next = (r_mode == obp_pkg::MODE_REPLACE) ? ST_ADD : ST_OUT;
      ST_ADD:   state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign rank_ok  = ({28'd0, r_index} < 32'(LEVELS));
  assign rank_lvl = r_side ? ask_cells[IW'(r_index)] : bid_cells[IW'(r_index)];
  assign bb       = bid_cells[0].price;
  assign ba       = ask_cells[0].price;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bid_total    <= '0;
      ask_total    <= '0;
      update_count <= '0;
      full         <= 1'b0;
      strobe       <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (state == ST_OUT);
      if (state == ST_IDLE && start) begin
        r_mode      <= mode;
        r_side      <= side;
        r_price     <= price;
        r_rep_price <= rep_price;
        r_qty       <= quantity;
        r_index     <= level_index;
        full        <= 1'b0;
      end
      if (state == ST_ERASE) begin
        update_count <= update_count + 32'd1;
        if (r_mode == obp_pkg::MODE_CLEAR) begin
          bid_total <= '0;
          ask_total <= '0;
        end
      end
      if (state == ST_ADD) begin
        update_count <= update_count + 32'd1;
        full         <= !s_any && s_last_valid;
      end
      if ((state == ST_ERASE && r_mode != obp_pkg::MODE_CLEAR) || state == ST_ADD) begin
        if (r_side) begin
          ask_total <= s_total_next;
        end else begin
          bid_total <= s_total_next;
        end
      end
      if (state == ST_OUT) begin
        best_bid <= bb;
        best_ask <= ba;
        if (bb == 32'd0 || ba == 32'd0) begin
          spread         <= '0;
          mid_half_ticks <= '0;
        end else begin
          spread         <= $signed({1'b0, ba}) - $signed({1'b0, bb});
          mid_half_ticks <= {1'b0, ba} + {1'b0, bb};
        end
        bid_volume         <= (bid_total > TW'(obp_pkg::MAX36)) ? obp_pkg::MAX36
                                                                  : bid_total[35:0];
        ask_volume         <= (ask_total > TW'(obp_pkg::MAX36)) ? obp_pkg::MAX36
                                                                  : ask_total[35:0];
        liquidity_at_price <= s_hit;
        if (rank_ok && rank_lvl.valid) begin
          level_price    <= rank_lvl.price;
          level_quantity <= rank_lvl.qty;
          level_valid    <= 1'b1;
        end else begin
          level_price    <= '0;
          level_quantity <= '0;
          level_valid    <= 1'b0;
        end
        side_full <= full;
      end
    end
  end
endmodule

FILE: bench/price_level_order_book_test.sv
// Self-checking bench for price_level_order_book: drives add, remove, replace,
// clear and query items and checks every result against a scoreboard model.
// Depends on obp_pkg and the order book RTL.
`timescale 1ns / 100ps

class book_scoreboard;
  logic [31:0] bpx[2][16];
  logic [31:0] bqty[2][16];
  int          used[2];
  logic [31:0] upd_count;
  logic [331:0] pending[$];
  int          errors;

  function new();
    errors = 0;
    upd_count = '0;
    used[0] = 0;
    used[1] = 0;
  endfunction

  function int find_px(bit s, logic [31:0] p);
    for (int i = 0; i < used[s]; i++)
      if (bpx[s][i] == p) return i;
    return -1;
  endfunction

  function void erase_at(bit s, int idx);
    for (int i = idx; i + 1 < used[s]; i++) begin
      bpx[s][i] = bpx[s][i + 1];
      bqty[s][i] = bqty[s][i + 1];
    end
    used[s]--;
    bpx[s][used[s]] = '0;
    bqty[s][used[s]] = '0;
  endfunction

  function bit merge_level(bit s, logic [31:0] p, logic [31:0] q);
    int f;
    int pos;
    logic [32:0] sum;
    f = find_px(s, p);
    if (f >= 0) begin
      sum = {1'b0, bqty[s][f]} + {1'b0, q};
      bqty[s][f] = sum[32] ? 32'hFFFFFFFF : sum[31:0];
      return 0;
    end
    if (used[s] >= 16) return 1;
    pos = 0;
    while (pos < used[s] && !(s ? (p < bpx[s][pos]) : (p > bpx[s][pos]))) pos++;
    for (int i = used[s]; i > pos; i--) begin
      bpx[s][i] = bpx[s][i - 1];
      bqty[s][i] = bqty[s][i - 1];
    end
    bpx[s][pos] = p;
    bqty[s][pos] = q;
    used[s]++;
    return 0;
  endfunction

  function logic [35:0] volume(bit s);
    logic [36:0] t;
    t = '0;
    for (int i = 0; i < used[s]; i++) t += {5'd0, bqty[s][i]};
    return t > 37'hFFFFFFFFF ? 36'hFFFFFFFFF : t[35:0];
  endfunction

  function void note_item(logic [2:0] m, bit s, logic [31:0] p, logic [31:0] np,
                          logic [31:0] q, logic [3:0] lidx);
    bit full;
    int f;
    logic [31:0] bb, ba, liq, lp, lq;
    logic [32:0] spr, mid;
    bit lv;
    logic [331:0] item;
    full = 0;
    case (m)
      obp_pkg::MODE_ADD: begin
        full = merge_level(s, p, q);
        upd_count++;
      end
      obp_pkg::MODE_REMOVE: begin
        f = find_px(s, p);
        if (f >= 0) begin
          if (q >= bqty[s][f]) erase_at(s, f);
          else bqty[s][f] -= q;
        end
        upd_count++;
      end
      obp_pkg::MODE_REPLACE: begin
        f = find_px(s, p);
        if (f >= 0) erase_at(s, f);
        full = merge_level(s, np, q);
        upd_count += 2;
      end
      obp_pkg::MODE_CLEAR: begin
        for (int k = 0; k < 2; k++)
          for (int i = 0; i < 16; i++) begin
            bpx[k][i] = '0;
            bqty[k][i] = '0;
          end
        used[0] = 0;
        used[1] = 0;
        upd_count++;
      end
      default: ;
    endcase
    bb = used[0] ? bpx[0][0] : '0;
    ba = used[1] ? bpx[1][0] : '0;
    if (bb == 0 || ba == 0) begin
      spr = '0;
      mid = '0;
    end else begin
      spr = {1'b0, ba} - {1'b0, bb};
      mid = {1'b0, ba} + {1'b0, bb};
    end
    f = find_px(s, p);
    liq = f >= 0 ? bqty[s][f] : '0;
    lv = lidx < used[s];
    lp = lv ? bpx[s][lidx] : '0;
    lq = lv ? bqty[s][lidx] : '0;
    item = {bb, ba, spr, mid, volume(0), volume(1), liq, lp, lq, lv, upd_count, full};
    pending = {pending, item};
  endfunction

  function void check_result(logic [331:0] got);
    logic [331:0] exp;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: bb %h/%h ba %h/%h spr %h/%h mid %h/%h bv %h/%h av %h/%h",
                 exp[331:300], got[331:300], exp[299:268], got[299:268],
                 exp[267:235], got[267:235], exp[234:202], got[234:202],
                 exp[201:166], got[201:166], exp[165:130], got[165:130]);
      if (errors <= 10)
        $display("  liq %h/%h lvl %h %h %b / %h %h %b cnt %h/%h full %b/%b",
                 exp[129:98], got[129:98], exp[97:66], exp[65:34], exp[33],
                 got[97:66], got[65:34], got[33], exp[32:1], got[32:1],
                 exp[0], got[0]);
    end
  endfunction
endclass

module price_level_order_book_test;
  logic clk, rst, start, busy, strobe;
  logic [2:0] mode;
  logic side;
  logic [31:0] price, rep_price, quantity;
  logic [3:0] level_index;
  logic [31:0] best_bid, best_ask, liquidity_at_price, level_price, level_quantity;
  logic signed [32:0] spread;
  logic [32:0] mid_half_ticks;
  logic [35:0] bid_volume, ask_volume;
  logic level_valid, side_full;
  logic [31:0] update_count;

  book_scoreboard sb;
  int idle_cycles;
  logic [31:0] px_pool[8];

  price_level_order_book u_top (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && strobe)
      sb.check_result({best_bid, best_ask, spread, mid_half_ticks, bid_volume,
                       ask_volume, liquidity_at_price, level_price, level_quantity,
                       level_valid, update_count, side_full});
    if (rst || (start && !busy) || strobe) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 2000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] m, bit s, logic [31:0] p, logic [31:0] np,
                           logic [31:0] q, logic [3:0] lidx);
    mode <= m;
    side <= s;
    price <= p;
    rep_price <= np;
    quantity <= q;
    level_index <= lidx;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_item(m, s, p, np, q, lidx);
    @(negedge clk);
  endtask

  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_px();
    case ($urandom_range(0, 3))
      0: return $urandom();
      default: return px_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic logic [31:0] pick_qty();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'hFFFFFFFF - $urandom_range(0, 3);
      2: return 32'd0;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  initial begin
    logic [2:0] m;
    sb = new();
    idle_cycles = 0;
    rst = 1;
    start = 0;
    mode = '0;
    side = 0;
    price = '0;
    rep_price = '0;
    quantity = '0;
    level_index = '0;
    for (int i = 0; i < 8; i++) px_pool[i] = 32'(100 + 3 * i);
    px_pool[6] = 32'hFFFFFFFF;
    px_pool[7] = 1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;
    // directed
    send_item(obp_pkg::MODE_QUERY, 0, 0, 0, 0, 0);
    send_item(obp_pkg::MODE_ADD, 0, 100, 0, 10, 0);
    send_item(obp_pkg::MODE_ADD, 1, 0, 0, 5, 0);
    send_item(obp_pkg::MODE_ADD, 1, 105, 0, 0, 1);
    send_item(obp_pkg::MODE_ADD, 0, 100, 0, 32'hFFFFFFFF, 0);
    send_item(obp_pkg::MODE_ADD, 0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 15);
    send_item(obp_pkg::MODE_REMOVE, 0, 77, 0, 1, 0);
    send_item(obp_pkg::MODE_REMOVE, 0, 100, 0, 5, 1);
    send_item(obp_pkg::MODE_REMOVE, 0, 100, 0, 32'hFFFFFFFF, 0);
    send_item(obp_pkg::MODE_REPLACE, 1, 105, 32'hFFFFFFFF, 7, 1);
    send_item(obp_pkg::MODE_REPLACE, 1, 999, 50, 3, 0);
    send_item(3'd5, 1, 50, 0, 0, 0);
    send_item(3'd7, 0, 0, 0, 0, 15);
    for (int i = 0; i < 18; i++)
      send_item(obp_pkg::MODE_ADD, 0, 32'(200 + i), 0, 32'hFFFFFFFF, 15);
    send_item(obp_pkg::MODE_REPLACE, 0, 1, 5000, 1, 0);
    send_item(obp_pkg::MODE_CLEAR, 1, 0, 0, 0, 0);
    // random
    for (int n = 0; n < 850; n++) begin
      if (n % 200 == 100) for (int i = 0; i < 8; i++) px_pool[i] = $urandom();
      case ($urandom_range(0, 19))
        0: m = obp_pkg::MODE_CLEAR;
        1, 2: m = 3'($urandom_range(4, 7));
        3, 4, 5: m = obp_pkg::MODE_REPLACE;
        6, 7, 8, 9: m = obp_pkg::MODE_REMOVE;
        default: m = obp_pkg::MODE_ADD;
      endcase
      if (n < 400 && m == obp_pkg::MODE_CLEAR && $urandom_range(0, 3) != 0)
        m = obp_pkg::MODE_ADD;
      send_item(m, 1'($urandom_range(0, 1)), pick_px(),
                ($urandom_range(0, 3) == 0) ? $urandom() : pick_px() + $urandom_range(0, 40),
                pick_qty(), 4'($urandom_range(0, 15)));
      random_gap();
    end
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
